/* sv/uvs_pkg.sv */
`default_nettype none

package uvs_pkg;

    localparam int MAX_SEGMENTS_DEF = 256;
    localparam int MIN_WIDTH_SEG    = 3;
    localparam int MIN_HEIGHT_SEG   = 2;
    localparam int TURN_BITS        = 20;
    localparam int CORDIC_ITERS     = 18;
    localparam int QUO_W            = 21;
    localparam int NUM_W            = 30;
    localparam int QUEUE_DEPTH      = 4;

    localparam logic [15:0] RADIUS_RST = 16'd256;
    localparam logic [8:0]  WIDTH_RST  = 9'd32;
    localparam logic [8:0]  HEIGHT_RST = 9'd16;

    localparam logic [1:0] CFG_RADIUS = 2'd0;
    localparam logic [1:0] CFG_WIDTH  = 2'd1;
    localparam logic [1:0] CFG_HEIGHT = 2'd2;

    typedef struct packed {
        logic [8:0]  col;
        logic [8:0]  row;
        logic [16:0] index;
        logic        quad;
    } item_t;

    typedef struct packed {
        logic [8:0] w;
        logic [8:0] h;
    } seg_t;

    typedef struct packed {
        logic [16:0] index;
        logic        quad;
        logic [16:0] tex_u;
        logic [16:0] tex_v;
    } side_t;

endpackage

`default_nettype wire

/* sv/uvs_front.sv */
`default_nettype none

module uvs_front
    import uvs_pkg::*;
#(
    parameter int MAX_SEGMENTS = MAX_SEGMENTS_DEF
)(
    input  wire logic [8:0] col,
    input  wire logic [8:0] row,
    input  wire logic [8:0] width_cfg,
    input  wire logic [8:0] height_cfg,
    output seg_t            seg,
    output item_t           item
);

    logic [8:0]  wc, hc, colc, rowc;
    logic [18:0] prod;

    always_comb
    begin
        // saturate segment counts
        if (int'(width_cfg) > MAX_SEGMENTS)
            wc = 9'(MAX_SEGMENTS);
        else if (int'(width_cfg) < MIN_WIDTH_SEG)
            wc = 9'(MIN_WIDTH_SEG);
        else
            wc = width_cfg;
        if (int'(height_cfg) > MAX_SEGMENTS)
            hc = 9'(MAX_SEGMENTS);
        else if (int'(height_cfg) < MIN_HEIGHT_SEG)
            hc = 9'(MIN_HEIGHT_SEG);
        else
            hc = height_cfg;
        colc = (col > wc) ? wc : col;
        rowc = (row > hc) ? hc : row;
        prod = (19'(wc) + 19'd1) * 19'(rowc);
        seg.w      = wc;
        seg.h      = hc;
        item.col   = colc;
        item.row   = rowc;
        item.index = 17'(prod + 19'(colc));
        item.quad  = (colc < wc) && (rowc < hc);
    end

endmodule

`default_nettype wire

/* sv/uvs_fifo.sv */
`default_nettype none

module uvs_fifo
    import uvs_pkg::*;
(
    input  wire logic  clk,
    input  wire logic  rst_n,
    input  wire logic  wr_en,
    input  wire item_t wr_data,
    input  wire logic  rd_en,
    output item_t      rd_data,
    output logic       full,
    output logic       empty
);

    localparam int PTR_W = $clog2(QUEUE_DEPTH);
    localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

    item_t            mem_reg [QUEUE_DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, rd_ptr_reg;
    logic [CNT_W-1:0] cnt_reg;

    assign full    = (cnt_reg == CNT_W'(QUEUE_DEPTH));
    assign empty   = (cnt_reg == '0);
    assign rd_data = mem_reg[rd_ptr_reg];

    always_ff @(posedge clk)
    begin
        if (wr_en)
            mem_reg[wr_ptr_reg] <= wr_data;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end
        else
        begin
            if (wr_en)
                wr_ptr_reg <= (wr_ptr_reg == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
            if (rd_en)
                rd_ptr_reg <= (rd_ptr_reg == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
            if (wr_en && !rd_en)
                cnt_reg <= cnt_reg + 1'b1;
            else if (rd_en && !wr_en)
                cnt_reg <= cnt_reg - 1'b1;
        end
    end

endmodule

`default_nettype wire

/* sv/uvs_div.sv */
`default_nettype none

module uvs_div
    import uvs_pkg::*;
(
    input  wire logic              clk,
    input  wire logic              en,
    input  wire logic [8:0]        den,
    input  wire logic [NUM_W-1:0]  num,
    output logic      [QUO_W-1:0]  quo
);

    // restoring division, one quotient bit per stage
    logic [8:0]       rem_reg [QUO_W];
    logic [QUO_W-1:0] acc_reg [QUO_W];

    assign quo = acc_reg[QUO_W-1];

    for (genvar k = 0; k < QUO_W; k++)
    begin : g_stage
        logic [8:0]       rem_in;
        logic [QUO_W-1:0] acc_in;
        logic [9:0]       trial;
        logic             ge;
        if (k == 0)
        begin : g_src
            assign rem_in = num[NUM_W-1:QUO_W];
            assign acc_in = num[QUO_W-1:0];
        end
        else
        begin : g_chain
            assign rem_in = rem_reg[k-1];
            assign acc_in = acc_reg[k-1];
        end
        assign trial = {rem_in, acc_in[QUO_W-1]};
        assign ge    = (trial >= {1'b0, den});
        always_ff @(posedge clk)
        begin
            if (en)
            begin
                rem_reg[k] <= ge ? 9'(trial - {1'b0, den}) : trial[8:0];
                acc_reg[k] <= {acc_in[QUO_W-2:0], ge};
            end
        end
    end

endmodule

`default_nettype wire

/* sv/uvs_back.sv */
`default_nettype none

module uvs_back
    import uvs_pkg::*;
(
    input  wire logic         clk,
    input  wire logic         rst_n,
    input  wire seg_t         seg,
    input  wire logic [15:0]  radius_cfg,
    input  wire item_t        head,
    input  wire logic         head_empty,
    output logic              head_take,
    input  wire logic         pop,
    output logic              empty,
    output logic signed [16:0] pos_x,
    output logic signed [16:0] pos_y,
    output logic signed [16:0] pos_z,
    output logic signed [15:0] norm_x,
    output logic signed [15:0] norm_y,
    output logic signed [15:0] norm_z,
    output logic [16:0]       tex_u,
    output logic [16:0]       tex_v,
    output logic [16:0]       vertex_index,
    output logic              quad_valid
);

    localparam int DIV_ST  = QUO_W;
    localparam int COR_END = DIV_ST + CORDIC_ITERS;
    localparam int FIN     = COR_END + 1;
    localparam int MUL     = FIN + 1;
    localparam logic signed [32:0] GAIN = 33'sd652032874;
    localparam logic signed [15:0] QMAX = 16'sd32767;

    function automatic logic signed [15:0] sat15(input logic signed [17:0] v);
        logic signed [15:0] r;
        if (v > 18'sd32767)
            r = QMAX;
        else if (v < -18'sd32767)
            r = -QMAX;
        else
            r = v[15:0];
        return r;
    endfunction

    function automatic logic [17:0] atan_val(input int i);
        logic [17:0] r;
        unique case (i)
            0:  r = 18'd131072;
            1:  r = 18'd77376;
            2:  r = 18'd40884;
            3:  r = 18'd20753;
            4:  r = 18'd10417;
            5:  r = 18'd5213;
            6:  r = 18'd2607;
            7:  r = 18'd1304;
            8:  r = 18'd652;
            9:  r = 18'd326;
            10: r = 18'd163;
            11: r = 18'd81;
            12: r = 18'd41;
            13: r = 18'd20;
            14: r = 18'd10;
            15: r = 18'd5;
            16: r = 18'd3;
            default: r = 18'd1;
        endcase
        return r;
    endfunction

    logic adv;
    logic out_vld_reg;

    // advance the whole pipeline whenever the output register frees up
    assign adv       = !out_vld_reg || pop;
    assign head_take = adv && !head_empty;
    assign empty     = !out_vld_reg;

    // dividers
    logic [NUM_W-1:0] n_phi, n_th, n_tu, n_tv;
    logic [QUO_W-1:0] q_phi, q_th, q_tu, q_tv;

    assign n_phi = (NUM_W'(head.col) << TURN_BITS) + NUM_W'(seg.w[8:1]);
    assign n_tu  = (NUM_W'(head.col) << 16) + NUM_W'(seg.w[8:1]);
    assign n_th  = (NUM_W'(head.row) << (TURN_BITS - 1)) + NUM_W'(seg.h[8:1]);
    assign n_tv  = (NUM_W'(head.row) << 16) + NUM_W'(seg.h[8:1]);

    uvs_div u_div_phi (.clk(clk), .en(adv), .den(seg.w), .num(n_phi), .quo(q_phi));
    uvs_div u_div_tu  (.clk(clk), .en(adv), .den(seg.w), .num(n_tu),  .quo(q_tu));
    uvs_div u_div_th  (.clk(clk), .en(adv), .den(seg.h), .num(n_th),  .quo(q_th));
    uvs_div u_div_tv  (.clk(clk), .en(adv), .den(seg.h), .num(n_tv),  .quo(q_tv));

    // side payload and valid line
    logic  vld_reg  [1:MUL];
    side_t side_reg [1:MUL];

    for (genvar k = 1; k <= MUL; k++)
    begin : g_line
        if (k == 1)
        begin : g_first
            always_ff @(posedge clk or negedge rst_n)
            begin
                if (!rst_n)
                    vld_reg[k] <= 1'b0;
                else if (adv)
                    vld_reg[k] <= !head_empty;
            end
            always_ff @(posedge clk)
            begin
                if (adv)
                begin
                    side_reg[k].index <= head.index;
                    side_reg[k].quad  <= head.quad;
                    side_reg[k].tex_u <= '0;
                    side_reg[k].tex_v <= '0;
                end
            end
        end
        else
        begin : g_rest
            always_ff @(posedge clk or negedge rst_n)
            begin
                if (!rst_n)
                    vld_reg[k] <= 1'b0;
                else if (adv)
                    vld_reg[k] <= vld_reg[k-1];
            end
            always_ff @(posedge clk)
            begin
                if (adv)
                begin
                    // pick up the texture quotients as they leave the dividers
                    if (k == DIV_ST + 1)
                        side_reg[k] <= {side_reg[k-1].index, side_reg[k-1].quad,
                                        q_tu[16:0], 17'd65536 - q_tv[16:0]};
                    else
                        side_reg[k] <= side_reg[k-1];
                end
            end
        end
    end

    // two CORDIC rotators: channel 0 for phi, channel 1 for theta
    logic signed [32:0] cx  [2][CORDIC_ITERS];
    logic signed [32:0] cy  [2][CORDIC_ITERS];
    logic signed [20:0] cz  [2][CORDIC_ITERS];
    logic [1:0]         cq  [2][CORDIC_ITERS];
    logic               czr [2][CORDIC_ITERS];
    logic [TURN_BITS-1:0] ang [2];

    assign ang[0] = q_phi[TURN_BITS-1:0];
    assign ang[1] = q_th[TURN_BITS-1:0];

    logic signed [15:0] c_fin_reg [2];
    logic signed [15:0] s_fin_reg [2];

    for (genvar ch = 0; ch < 2; ch++)
    begin : g_ch
        for (genvar j = 0; j < CORDIC_ITERS; j++)
        begin : g_it
            localparam logic signed [20:0] AT = 21'(atan_val(j));
            logic signed [32:0] xi, yi, dx, dy;
            logic signed [20:0] zi;
            logic [1:0]         qi;
            logic               zri;
            if (j == 0)
            begin : g_src
                assign xi  = GAIN;
                assign yi  = '0;
                assign zi  = 21'(ang[ch][TURN_BITS-3:0]);
                assign qi  = ang[ch][TURN_BITS-1:TURN_BITS-2];
                assign zri = (ang[ch][TURN_BITS-3:0] == '0);
            end
            else
            begin : g_chain
                assign xi  = cx[ch][j-1];
                assign yi  = cy[ch][j-1];
                assign zi  = cz[ch][j-1];
                assign qi  = cq[ch][j-1];
                assign zri = czr[ch][j-1];
            end
            assign dx = yi >>> j;
            assign dy = xi >>> j;
            always_ff @(posedge clk)
            begin
                if (adv)
                begin
                    if (!zi[20])
                    begin
                        cx[ch][j] <= xi - dx;
                        cy[ch][j] <= yi + dy;
                        cz[ch][j] <= zi - AT;
                    end
                    else
                    begin
                        cx[ch][j] <= xi + dx;
                        cy[ch][j] <= yi - dy;
                        cz[ch][j] <= zi + AT;
                    end
                    cq[ch][j]  <= qi;
                    czr[ch][j] <= zri;
                end
            end
        end

        // round, snap exact axes, unfold quadrant
        logic signed [32:0] xr, yr;
        logic signed [15:0] c0, s0;
        assign xr = cx[ch][CORDIC_ITERS-1] + 33'sd16384;
        assign yr = cy[ch][CORDIC_ITERS-1] + 33'sd16384;
        assign c0 = czr[ch][CORDIC_ITERS-1] ? QMAX : sat15(18'(xr >>> 15));
        assign s0 = czr[ch][CORDIC_ITERS-1] ? 16'sd0 : sat15(18'(yr >>> 15));

        always_ff @(posedge clk)
        begin
            if (adv)
            begin
                unique case (cq[ch][CORDIC_ITERS-1])
                    2'd0:
                    begin
                        c_fin_reg[ch] <= c0;
                        s_fin_reg[ch] <= s0;
                    end
                    2'd1:
                    begin
                        c_fin_reg[ch] <= -s0;
                        s_fin_reg[ch] <= c0;
                    end
                    2'd2:
                    begin
                        c_fin_reg[ch] <= -c0;
                        s_fin_reg[ch] <= -s0;
                    end
                    default:
                    begin
                        c_fin_reg[ch] <= s0;
                        s_fin_reg[ch] <= -c0;
                    end
                endcase
            end
        end
    end

    // normal products
    logic signed [31:0] pxs, pzs;
    logic signed [15:0] nx_reg, ny_reg, nz_reg;

    assign pxs = c_fin_reg[0] * s_fin_reg[1] + 32'sd16384;
    assign pzs = s_fin_reg[0] * s_fin_reg[1] + 32'sd16384;

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            nx_reg <= -sat15(18'(pxs >>> 15));
            ny_reg <= c_fin_reg[1];
            nz_reg <= sat15(18'(pzs >>> 15));
        end
    end

    // scale by radius into the output register
    logic signed [16:0] rad_s;
    logic signed [32:0] rx, ry, rz;

    assign rad_s = signed'({1'b0, radius_cfg});
    assign rx    = rad_s * nx_reg + 33'sd16384;
    assign ry    = rad_s * ny_reg + 33'sd16384;
    assign rz    = rad_s * nz_reg + 33'sd16384;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_vld_reg <= 1'b0;
        else if (adv)
            out_vld_reg <= vld_reg[MUL];
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            pos_x        <= 17'(rx >>> 15);
            pos_y        <= 17'(ry >>> 15);
            pos_z        <= 17'(rz >>> 15);
            norm_x       <= nx_reg;
            norm_y       <= ny_reg;
            norm_z       <= nz_reg;
            tex_u        <= side_reg[MUL].tex_u;
            tex_v        <= side_reg[MUL].tex_v;
            vertex_index <= side_reg[MUL].index;
            quad_valid   <= side_reg[MUL].quad;
        end
    end

endmodule

`default_nettype wire

/* sv/uv_sphere_vertex_generator_unit.sv */
// Path: a request passes from the input queue through 21 divider stages, 18 CORDIC stages,
//   round, normal and scale to the result ports.
// Throughput: one request per cycle; the pipeline stalls as a whole only while a
//   finished result waits to be popped, and the 4-entry input queue fills meanwhile.
// Reset (rst_n low, async): queue and pipeline empty, radius 256, 32 x 16 segments.
`default_nettype none

module uv_sphere_vertex_generator_unit
    import uvs_pkg::*;
#(
    parameter int MAX_SEGMENTS = MAX_SEGMENTS_DEF
)(
    input  wire logic         clk,
    input  wire logic         rst_n,
    // request side
    input  wire logic         push,
    output logic              full,
    input  wire logic [8:0]   col,
    input  wire logic [8:0]   row,
    // result side
    output logic              empty,
    input  wire logic         pop,
    output logic signed [16:0] pos_x,
    output logic signed [16:0] pos_y,
    output logic signed [16:0] pos_z,
    output logic signed [15:0] norm_x,
    output logic signed [15:0] norm_y,
    output logic signed [15:0] norm_z,
    output logic [16:0]       tex_u,
    output logic [16:0]       tex_v,
    output logic [16:0]       vertex_index,
    output logic              quad_valid,
    // configuration writes
    input  wire logic         cfg_valid,
    output logic              cfg_ready,
    input  wire logic [1:0]   cfg_index,
    input  wire logic [15:0]  cfg_data
);

    logic [15:0] radius_reg;
    logic [8:0]  width_reg;
    logic [8:0]  height_reg;

    // always take configuration; the sender writes only while nothing is in flight
    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            radius_reg <= RADIUS_RST;
            width_reg  <= WIDTH_RST;
            height_reg <= HEIGHT_RST;
        end
        else if (cfg_valid)
        begin
            unique case (cfg_index)
                CFG_RADIUS: radius_reg <= cfg_data;
                CFG_WIDTH:  width_reg  <= cfg_data[8:0];
                CFG_HEIGHT: height_reg <= cfg_data[8:0];
                default:    ; // drop writes to unknown registers
            endcase
        end
    end

    // front: clamp coordinates, compute index and quad flag
    seg_t  seg;
    item_t item;

    uvs_front #(
        .MAX_SEGMENTS(MAX_SEGMENTS)
    ) u_front (
        .col        (col),
        .row        (row),
        .width_cfg  (width_reg),
        .height_cfg (height_reg),
        .seg        (seg),
        .item       (item)
    );

    // queue between front and back
    item_t head;
    logic  head_empty;
    logic  head_take;

    uvs_fifo u_fifo (
        .clk     (clk),
        .rst_n   (rst_n),
        .wr_en   (push && !full),
        .wr_data (item),
        .rd_en   (head_take),
        .rd_data (head),
        .full    (full),
        .empty   (head_empty)
    );

    // back: divide, rotate, scale
    uvs_back u_back (
        .clk          (clk),
        .rst_n        (rst_n),
        .seg          (seg),
        .radius_cfg   (radius_reg),
        .head         (head),
        .head_empty   (head_empty),
        .head_take    (head_take),
        .pop          (pop),
        .empty        (empty),
        .pos_x        (pos_x),
        .pos_y        (pos_y),
        .pos_z        (pos_z),
        .norm_x       (norm_x),
        .norm_y       (norm_y),
        .norm_z       (norm_z),
        .tex_u        (tex_u),
        .tex_v        (tex_v),
        .vertex_index (vertex_index),
        .quad_valid   (quad_valid)
    );

endmodule

`default_nettype wire
